@@ sv/sra_pkg.sv @@
package sra_pkg;

    localparam int CMD_W    = 2;
    localparam int QUEUE_W  = 2;
    localparam int SLOT_W   = 5;
    localparam int STAT_W   = 2;
    localparam int CNT_W    = 6;
    localparam int PTR_W    = 6;
    localparam int END_W    = 7;
    localparam int SETUP_W  = 20;
    localparam int CFG_IDX_W = 3;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 16;

    localparam logic [SLOT_W-1:0] RESERVED_RESET = 5'd29;

    localparam logic [CFG_IDX_W-1:0] REG_QUEUE0   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RESERVED = 3'd4;

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC = 2'd0,
        CMD_FREE  = 2'd1,
        CMD_COUNT = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK      = 2'd0,
        ST_NONE    = 2'd1,
        ST_CLOSED  = 2'd2,
        ST_ALREADY = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_PREF,
        S_LOW,
        S_FREE,
        S_COUNT,
        S_DONE
    } state_t;

    typedef struct packed {
        logic             allow_reserved;
        logic             open;
        logic [PTR_W-1:0] pref;
        logic [PTR_W-1:0] high;
        logic [PTR_W-1:0] low;
    } setup_t;

    typedef struct packed {
        logic             load;
        logic [PTR_W-1:0] load_val;
        logic             step;
        logic             cnt_clr;
        logic             count;
    } scan_ctrl_t;

    typedef struct packed {
        logic in_range;
        logic busy;
        logic takeable;
    } scan_stat_t;

endpackage

@@ sv/sra_bitmap.sv @@
module sra_bitmap #(
    parameter int NUM_SLOTS = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [$clog2(NUM_SLOTS)-1:0] index,
    input  logic                         set_en,
    input  logic                         clr_en,
    output logic                         busy
);

    logic [NUM_SLOTS-1:0] used_reg;
    logic [NUM_SLOTS-1:0] used_next;

    always_comb
    begin
        used_next = used_reg;
        if (set_en)
        begin
            used_next[index] = 1'b1;
        end
        else if (clr_en)
        begin
            used_next[index] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
        end
        else
        begin
            used_reg <= used_next;
        end
    end

    assign busy = used_reg[index];

endmodule

@@ sv/sra_scan.sv @@
module sra_scan (
    input  logic                             clk,
    input  sra_pkg::scan_ctrl_t              ctrl,
    input  logic [sra_pkg::END_W-1:0]        limit,
    input  logic [sra_pkg::SLOT_W-1:0]       reserved_slot,
    input  logic                             allow_reserved,
    input  logic                             busy,
    output sra_pkg::scan_stat_t              stat,
    output logic [sra_pkg::PTR_W-1:0]        ptr,
    output logic [sra_pkg::CNT_W-1:0]        cnt
);

    logic [sra_pkg::PTR_W-1:0] ptr_reg;
    logic [sra_pkg::PTR_W-1:0] ptr_next;
    logic [sra_pkg::CNT_W-1:0] cnt_reg;
    logic [sra_pkg::CNT_W-1:0] cnt_next;
    logic                      is_reserved;

    always_comb
    begin
        stat.in_range = {1'b0, ptr_reg} < limit;
        stat.busy     = busy;
        is_reserved   = ptr_reg == {1'b0, reserved_slot};
        stat.takeable = stat.in_range && !busy && !(is_reserved && !allow_reserved);

        if (ctrl.load)
        begin
            ptr_next = ctrl.load_val;
        end
        else if (ctrl.step)
        begin
            ptr_next = ptr_reg + 1'b1;
        end
        else
        begin
            ptr_next = ptr_reg;
        end

        if (ctrl.cnt_clr)
        begin
            cnt_next = '0;
        end
        else if (ctrl.count && stat.in_range && !busy)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else
        begin
            cnt_next = cnt_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg <= ptr_next;
        cnt_reg <= cnt_next;
    end

    assign ptr = ptr_reg;
    assign cnt = cnt_reg;

endmodule

@@ sv/slot_range_allocator.sv @@
// slot range allocator: one in-use bit per slot, all free after reset.
// commands arrive on the s_ stream, one word each: allocate for a queue,
// free a slot, or count the free slots of a queue's range. every command
// gives exactly one result word on the m_ stream (status, granted slot,
// free count).
// queue setups and the reserved slot are written through cfg_we, cfg_index
// and cfg_data; the user must do so only while the block is idle; it is not enforced.
// a command is first decoded, then a shared compare and
// increment unit walks the bitmap one slot per cycle: allocate scans from
// the preferred slot when it is nonzero and then from the low slot; count
// scans the range once; free checks a single slot. the result then moves
// into the output register once that register is empty or draining.
// s_tready is high only while no command is in work.
// a result waits in the output register while m_tready is low; the next
// command is still taken, and its result is held back until the register
// drains. reset frees every slot, clears the queue setups and sets the
// reserved slot to 29.
module slot_range_allocator #(
    parameter int NUM_SLOTS  = 32,
    parameter int NUM_QUEUES = 4
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [sra_pkg::IN_DATA_W-1:0]     s_tdata,   // cmd, queue, slot
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [sra_pkg::OUT_DATA_W-1:0]    m_tdata,   // status, granted_slot, free_count
    input  logic                              cfg_we,
    input  logic [sra_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sra_pkg::SETUP_W-1:0]       cfg_data
);

    localparam int IDX_W = $clog2(NUM_SLOTS);

    sra_pkg::setup_t                 setup_regs [NUM_QUEUES];
    logic [sra_pkg::SLOT_W-1:0]      reserved_reg;

    sra_pkg::state_t                 state_reg;
    sra_pkg::state_t                 state_next;
    sra_pkg::cmd_t                   cmd_reg;
    logic [sra_pkg::SLOT_W-1:0]      slot_reg;
    sra_pkg::setup_t                 setup_reg;
    logic                            qok_reg;
    sra_pkg::status_t                res_status_reg;
    sra_pkg::status_t                res_status_next;
    logic [sra_pkg::SLOT_W-1:0]      res_slot_reg;
    logic [sra_pkg::SLOT_W-1:0]      res_slot_next;

    logic                            out_valid_reg;
    logic                            out_valid_next;
    logic [sra_pkg::STAT_W-1:0]      out_status_reg;
    logic [sra_pkg::SLOT_W-1:0]      out_slot_reg;
    logic [sra_pkg::CNT_W-1:0]       out_count_reg;

    logic [sra_pkg::CMD_W-1:0]       in_cmd;
    logic [sra_pkg::QUEUE_W-1:0]     in_queue;
    logic [sra_pkg::SLOT_W-1:0]      in_slot;
    sra_pkg::setup_t                 sel_setup;
    logic                            sel_ok;
    logic                            accept;
    logic                            out_load;

    sra_pkg::scan_ctrl_t             scan_ctrl;
    sra_pkg::scan_stat_t             scan_stat;
    logic [sra_pkg::PTR_W-1:0]       ptr;
    logic [sra_pkg::CNT_W-1:0]       cnt;
    logic [sra_pkg::END_W-1:0]       range_end;
    logic [sra_pkg::END_W-1:0]       limit;
    logic                            busy;
    logic                            set_en;
    logic                            clr_en;

    assign in_cmd   = s_tdata[1:0];
    assign in_queue = s_tdata[3:2];
    assign in_slot  = s_tdata[8:4];
    assign s_tready = state_reg == sra_pkg::S_IDLE;
    assign accept   = s_tvalid && s_tready;

    // queue setup lookup
    always_comb
    begin
        sel_setup = '0;
        sel_ok    = 1'b0;
        for (int q = 0; q < NUM_QUEUES; q++)
        begin
            if (in_queue == sra_pkg::QUEUE_W'(q))
            begin
                sel_setup = setup_regs[q];
                sel_ok    = 1'b1;
            end
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int q = 0; q < NUM_QUEUES; q++)
            begin
                setup_regs[q] <= '0;
            end
            reserved_reg <= sra_pkg::RESERVED_RESET;
        end
        else if (cfg_we)
        begin
            for (int q = 0; q < NUM_QUEUES; q++)
            begin
                if (cfg_index == sra_pkg::REG_QUEUE0 + sra_pkg::CFG_IDX_W'(q))
                begin
                    setup_regs[q] <= cfg_data;
                end
            end
            if (cfg_index == sra_pkg::REG_RESERVED)
            begin
                reserved_reg <= cfg_data[sra_pkg::SLOT_W-1:0];
            end
        end
    end

    // range end cut at the slot count
    always_comb
    begin
        if ({1'b0, setup_reg.high} > sra_pkg::END_W'(NUM_SLOTS))
        begin
            range_end = sra_pkg::END_W'(NUM_SLOTS);
        end
        else
        begin
            range_end = {1'b0, setup_reg.high};
        end
        limit = (state_reg == sra_pkg::S_FREE) ? sra_pkg::END_W'(NUM_SLOTS) : range_end;
    end

    sra_scan u_scan (
        .clk            (clk),
        .ctrl           (scan_ctrl),
        .limit          (limit),
        .reserved_slot  (reserved_reg),
        .allow_reserved (setup_reg.allow_reserved),
        .busy           (busy),
        .stat           (scan_stat),
        .ptr            (ptr),
        .cnt            (cnt)
    );

    sra_bitmap #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_bitmap (
        .clk    (clk),
        .rst_n  (rst_n),
        .index  (ptr[IDX_W-1:0]),
        .set_en (set_en),
        .clr_en (clr_en),
        .busy   (busy)
    );

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        scan_ctrl       = '0;
        set_en          = 1'b0;
        clr_en          = 1'b0;
        out_load        = 1'b0;

        case (state_reg)
            sra_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    state_next = sra_pkg::S_DECODE;
                end
            end
            sra_pkg::S_DECODE:
            begin
                res_status_next   = sra_pkg::ST_OK;
                res_slot_next     = '0;
                scan_ctrl.cnt_clr = 1'b1;
                case (cmd_reg)
                    sra_pkg::CMD_ALLOC:
                    begin
                        if (!qok_reg || !setup_reg.open)
                        begin
                            res_status_next = sra_pkg::ST_CLOSED;
                            state_next      = sra_pkg::S_DONE;
                        end
                        else if (setup_reg.pref != '0)
                        begin
                            scan_ctrl.load     = 1'b1;
                            scan_ctrl.load_val = setup_reg.pref;
                            state_next         = sra_pkg::S_PREF;
                        end
                        else
                        begin
                            scan_ctrl.load     = 1'b1;
                            scan_ctrl.load_val = setup_reg.low;
                            state_next         = sra_pkg::S_LOW;
                        end
                    end
                    sra_pkg::CMD_FREE:
                    begin
                        scan_ctrl.load     = 1'b1;
                        scan_ctrl.load_val = {1'b0, slot_reg};
                        state_next         = sra_pkg::S_FREE;
                    end
                    sra_pkg::CMD_COUNT:
                    begin
                        if (!qok_reg)
                        begin
                            state_next = sra_pkg::S_DONE;
                        end
                        else
                        begin
                            scan_ctrl.load     = 1'b1;
                            scan_ctrl.load_val = setup_reg.low;
                            state_next         = sra_pkg::S_COUNT;
                        end
                    end
                    default:
                    begin
                        state_next = sra_pkg::S_DONE;
                    end
                endcase
            end
            sra_pkg::S_PREF, sra_pkg::S_LOW:
            begin
                if (!scan_stat.in_range)
                begin
                    if (state_reg == sra_pkg::S_PREF)
                    begin
                        scan_ctrl.load     = 1'b1;
                        scan_ctrl.load_val = setup_reg.low;
                        state_next         = sra_pkg::S_LOW;
                    end
                    else
                    begin
                        res_status_next = sra_pkg::ST_NONE;
                        state_next      = sra_pkg::S_DONE;
                    end
                end
                else if (scan_stat.takeable)
                begin
                    set_en          = 1'b1;
                    res_status_next = sra_pkg::ST_OK;
                    res_slot_next   = ptr[sra_pkg::SLOT_W-1:0];
                    state_next      = sra_pkg::S_DONE;
                end
                else
                begin
                    scan_ctrl.step = 1'b1;
                end
            end
            sra_pkg::S_FREE:
            begin
                if (scan_stat.in_range && scan_stat.busy)
                begin
                    clr_en          = 1'b1;
                    res_status_next = sra_pkg::ST_OK;
                end
                else
                begin
                    res_status_next = sra_pkg::ST_ALREADY;
                end
                state_next = sra_pkg::S_DONE;
            end
            sra_pkg::S_COUNT:
            begin
                if (!scan_stat.in_range)
                begin
                    state_next = sra_pkg::S_DONE;
                end
                else
                begin
                    scan_ctrl.step  = 1'b1;
                    scan_ctrl.count = 1'b1;
                end
            end
            sra_pkg::S_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_load   = 1'b1;
                    state_next = sra_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = sra_pkg::S_IDLE;
            end
        endcase
    end

    assign out_valid_next = out_load || (out_valid_reg && !m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sra_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg   <= sra_pkg::cmd_t'(in_cmd);
            slot_reg  <= in_slot;
            setup_reg <= sel_setup;
            qok_reg   <= sel_ok;
        end
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        if (out_load)
        begin
            out_status_reg <= res_status_reg;
            out_slot_reg   <= res_slot_reg;
            out_count_reg  <= (cmd_reg == sra_pkg::CMD_COUNT) ? cnt : '0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_count_reg, out_slot_reg, out_status_reg};

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 100ps

module tb;

    localparam int NSLOT      = 32;
    localparam int NQ         = 4;
    localparam int SIDX_W     = $clog2(NSLOT);
    localparam int LIMIT      = 400000;
    localparam int TAIL       = 80;
    localparam int HOLD       = 400;
    localparam int IDLE_PCT   = 18;
    localparam int PHASES     = 5;
    localparam int PHASE_LEN  = 130;

    localparam logic [sra_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = sra_pkg::REG_RESERVED + 3'd1;
    localparam logic [sra_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    typedef struct {
        sra_pkg::cmd_t               op;
        logic [sra_pkg::QUEUE_W-1:0] qnum;
        logic [sra_pkg::SLOT_W-1:0]  slot;
    } request_t;

    typedef struct {
        sra_pkg::status_t            status;
        logic [sra_pkg::SLOT_W-1:0]  granted;
        logic [sra_pkg::CNT_W-1:0]   count;
    } reply_t;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [sra_pkg::IN_DATA_W-1:0]   s_tdata = '0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [sra_pkg::OUT_DATA_W-1:0]  m_tdata;
    logic                            cfg_we = 1'b0;
    logic [sra_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
    logic [sra_pkg::SETUP_W-1:0]     cfg_data = '0;

    // predictor state
    logic [NSLOT-1:0]                used_slots;
    sra_pkg::setup_t                 queue_setups [NQ];
    logic [sra_pkg::SLOT_W-1:0]      reserved_sel;

    request_t                        command_queue [$];
    reply_t                          expected_replies [$];
    request_t                        in_flight;
    logic                            s_taken = 1'b0;
    logic                            steady = 1'b0;
    logic                            hold_req = 1'b0;
    logic                            hold_taken = 1'b0;
    int                              hold_left = 0;
    int                              mismatches = 0;
    int                              cycles = 0;

    slot_range_allocator #(
        .NUM_SLOTS  (NSLOT),
        .NUM_QUEUES (NQ)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    function automatic int range_end(sra_pkg::setup_t su);
        return (su.high > NSLOT) ? NSLOT : int'(su.high);
    endfunction

    function automatic int first_free(sra_pkg::setup_t su, int from, int upto);
        for (int s = from; s < upto; s++)
            if (!used_slots[s[SIDX_W-1:0]] &&
                !(s == int'(reserved_sel) && !su.allow_reserved))
                return s;
        return -1;
    endfunction

    function automatic reply_t apply_command(request_t rq);
        reply_t          rp;
        sra_pkg::setup_t su;
        int              got;
        rp.status  = sra_pkg::ST_OK;
        rp.granted = '0;
        rp.count   = '0;
        su  = queue_setups[rq.qnum];
        got = -1;
        case (rq.op)
            sra_pkg::CMD_ALLOC:
            begin
                if (!su.open)
                    rp.status = sra_pkg::ST_CLOSED;
                else
                begin
                    if (su.pref != 0)
                        got = first_free(su, int'(su.pref), range_end(su));
                    if (got < 0)
                        got = first_free(su, int'(su.low), range_end(su));
                    if (got < 0)
                        rp.status = sra_pkg::ST_NONE;
                    else
                    begin
                        used_slots[got[SIDX_W-1:0]] = 1'b1;
                        rp.granted = got[sra_pkg::SLOT_W-1:0];
                    end
                end
            end
            sra_pkg::CMD_FREE:
            begin
                if (!used_slots[rq.slot])
                    rp.status = sra_pkg::ST_ALREADY;
                else
                    used_slots[rq.slot] = 1'b0;
            end
            sra_pkg::CMD_COUNT:
            begin
                for (int s = int'(su.low); s < range_end(su); s++)
                    if (!used_slots[s[SIDX_W-1:0]])
                        rp.count = rp.count + 1'b1;
            end
            default:
            begin
            end
        endcase
        return rp;
    endfunction

    function automatic request_t make_req(sra_pkg::cmd_t op, int q, int s);
        request_t rq;
        rq.op   = op;
        rq.qnum = q[sra_pkg::QUEUE_W-1:0];
        rq.slot = s[sra_pkg::SLOT_W-1:0];
        return rq;
    endfunction

    function automatic sra_pkg::setup_t make_setup(int lo, int hi, int pref, bit open, bit allow);
        sra_pkg::setup_t su;
        su.low            = lo[sra_pkg::PTR_W-1:0];
        su.high           = hi[sra_pkg::PTR_W-1:0];
        su.pref           = pref[sra_pkg::PTR_W-1:0];
        su.open           = open;
        su.allow_reserved = allow;
        return su;
    endfunction

    function automatic sra_pkg::setup_t random_setup();
        logic [sra_pkg::SETUP_W-1:0] raw;
        int                          lo;
        int                          hi;
        raw = sra_pkg::SETUP_W'($urandom);
        if ($urandom_range(9) == 0)
            return raw;
        lo = $urandom_range(0, 31);
        hi = ($urandom_range(7) == 0) ? $urandom_range(33, 63) : $urandom_range(lo + 1, 32);
        return make_setup(lo, hi, $urandom_range(1) ? 0 : $urandom_range(0, 40),
                          $urandom_range(9) != 0, 1'($urandom_range(1)));
    endfunction

    function automatic request_t random_request();
        int            pick;
        sra_pkg::cmd_t op;
        pick = $urandom_range(99);
        if (pick < 45)
            op = sra_pkg::CMD_ALLOC;
        else if (pick < 80)
            op = sra_pkg::CMD_FREE;
        else if (pick < 95)
            op = sra_pkg::CMD_COUNT;
        else
            op = sra_pkg::CMD_NONE;
        return make_req(op, $urandom_range(3), $urandom_range(31));
    endfunction

    task automatic write_reg(logic [sra_pkg::CFG_IDX_W-1:0] idx,
                             logic [sra_pkg::SETUP_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        if (idx < sra_pkg::REG_RESERVED)
            queue_setups[sra_pkg::QUEUE_W'(idx - sra_pkg::REG_QUEUE0)] = val;
        else if (idx == sra_pkg::REG_RESERVED)
            reserved_sel = val[sra_pkg::SLOT_W-1:0];
    endtask

    task automatic drain();
        while (command_queue.size() != 0 || s_tvalid || expected_replies.size() != 0)
        begin
            @(negedge clk);
            #1;
        end
        repeat (8) @(negedge clk);
    endtask

    task automatic compare_field(string what, int want, int got);
        if (want != got)
        begin
            mismatches++;
            $display("%0t: %s expected %0d, actual %0d", $time, what, want, got);
        end
    endtask

    // sender
    always @(negedge clk)
    begin
        if (rst_n && (!s_tvalid || s_taken))
        begin
            if (command_queue.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT))
            begin
                in_flight = command_queue.pop_front();
                s_tdata  <= {7'b0, in_flight.slot, in_flight.qnum, in_flight.op};
                s_tvalid <= 1'b1;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // receiver, with one long hold-off
    always @(negedge clk)
    begin
        if (hold_req && !hold_taken)
        begin
            hold_taken = 1'b1;
            hold_left  = HOLD;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= rst_n && (steady || $urandom_range(99) >= IDLE_PCT);
    end

    // monitor
    always @(posedge clk)
    begin
        reply_t want;
        if (rst_n)
        begin
            s_taken = s_tvalid && s_tready;
            if (s_taken)
                expected_replies.push_back(apply_command(in_flight));
            if (m_tvalid && m_tready)
            begin
                if (expected_replies.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: word with none expected, actual status %0d slot %0d count %0d",
                             $time, m_tdata[1:0], m_tdata[6:2], m_tdata[12:7]);
                end
                else
                begin
                    want = expected_replies.pop_front();
                    compare_field("status", want.status, m_tdata[1:0]);
                    compare_field("granted_slot", want.granted, m_tdata[6:2]);
                    compare_field("free_count", want.count, m_tdata[12:7]);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        sra_pkg::setup_t su;
        used_slots   = '0;
        reserved_sel = sra_pkg::RESERVED_RESET;
        for (int q = 0; q < NQ; q++)
            queue_setups[q[sra_pkg::QUEUE_W-1:0]] = '0;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // every queue is closed after reset
        command_queue.push_back(make_req(sra_pkg::CMD_ALLOC, 0, 31));
        drain();

        write_reg(sra_pkg::REG_QUEUE0 + 3'd0, make_setup(0, 63, 0, 1, 0));
        write_reg(sra_pkg::REG_QUEUE0 + 3'd1, make_setup(8, 16, 20, 1, 1));
        write_reg(sra_pkg::REG_QUEUE0 + 3'd2, make_setup(40, 10, 0, 1, 0));
        write_reg(sra_pkg::REG_QUEUE0 + 3'd3, make_setup(20, 63, 28, 1, 1));
        write_reg(sra_pkg::REG_RESERVED, 20'd5);
        write_reg(REG_SPARE_LO, 20'hFFFFF);
        write_reg(REG_SPARE_HI, 20'hFFFFF);

        command_queue.push_back(make_req(sra_pkg::CMD_COUNT, 0, 0));
        command_queue.push_back(make_req(sra_pkg::CMD_ALLOC, 2, 0));
        command_queue.push_back(make_req(sra_pkg::CMD_COUNT, 2, 31));
        repeat (7)
            command_queue.push_back(make_req(sra_pkg::CMD_ALLOC, 0, 0));
        command_queue.push_back(make_req(sra_pkg::CMD_ALLOC, 3, 0));
        command_queue.push_back(make_req(sra_pkg::CMD_ALLOC, 3, 31));
        command_queue.push_back(make_req(sra_pkg::CMD_ALLOC, 1, 0));
        command_queue.push_back(make_req(sra_pkg::CMD_FREE, 0, 31));
        command_queue.push_back(make_req(sra_pkg::CMD_FREE, 0, 0));
        command_queue.push_back(make_req(sra_pkg::CMD_FREE, 3, 0));
        command_queue.push_back(make_req(sra_pkg::CMD_NONE, 3, 31));
        command_queue.push_back(make_req(sra_pkg::CMD_COUNT, 3, 0));
        command_queue.push_back(make_req(sra_pkg::CMD_ALLOC, 0, 31));
        command_queue.push_back(make_req(sra_pkg::CMD_COUNT, 1, 0));
        drain();

        for (int ph = 0; ph < PHASES; ph++)
        begin
            for (int q = 0; q < NQ; q++)
            begin
                su = random_setup();
                if (ph == 0 && q == 3)
                    su = '0;
                if (ph == PHASES - 1 && q == 0)
                    su = '1;
                write_reg(sra_pkg::REG_QUEUE0 + q[sra_pkg::CFG_IDX_W-1:0], su);
            end
            if (ph == 0)
                write_reg(sra_pkg::REG_RESERVED, 20'd0);
            else if (ph == PHASES - 1)
                write_reg(sra_pkg::REG_RESERVED, 20'd31);
            else
                write_reg(sra_pkg::REG_RESERVED, sra_pkg::SETUP_W'($urandom_range(0, 31)));

            steady = (ph == 2);
            for (int i = 0; i < PHASE_LEN; i++)
            begin
                command_queue.push_back(random_request());
                if (ph == 3 && i == PHASE_LEN / 2)
                    drain();
            end
            if (ph == 1)
            begin
                @(posedge clk);
                hold_req = 1'b1;
            end
            drain();
            steady = 1'b0;
        end

        repeat (TAIL) @(posedge clk);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
